>>> sv/eps_pkg.sv
package eps_pkg;

    // Q format of the averages and carries
    localparam int FRAC     = 16;
    localparam int AVG_W    = 8 + FRAC;       // signed Q8.F average
    localparam int REM_W    = 1 + FRAC;       // signed Q1.F carry
    localparam int FACTOR_W = 17;             // Q0.16 factor register, 65536 = 1.0
    localparam int ALPHA_W  = FRAC + 1;       // Q0.F alpha, 2^F = 1.0
    localparam int DIFF_W   = AVG_W + 1;
    localparam int PROD_W   = DIFF_W + ALPHA_W + 1;
    localparam int P_W      = PROD_W + 1;
    localparam int SUM_W    = AVG_W + 1;
    localparam int Q_W      = SUM_W - FRAC;   // integer part of the sum
    localparam int R_W      = SUM_W + 1;

    // Q0.16 factor rescaled to Q0.F
    localparam int UP_SHIFT   = (FRAC > 16) ? FRAC - 16 : 0;
    localparam int DOWN_SHIFT = (FRAC < 16) ? 16 - FRAC : 0;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << 16;
    localparam logic [FRAC-1:0]     FRAC_MASK  = {FRAC{1'b1}};

    localparam int CFG_AW = 4;

    typedef enum logic [1:0] {
        CFG_FACTOR  = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_ENABLE  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic signed [7:0]       out;
        logic signed [AVG_W-1:0] avg;
        logic signed [REM_W-1:0] rem;
    } t_axis;

    // One EMA step on one axis: alpha*d + (1-alpha)*avg, written as
    // avg*2^F + alpha*(d*2^F - avg) so a single multiplier does it.
    function automatic t_axis eps_axis(input logic signed [7:0]       d,
                                       input logic signed [AVG_W-1:0] avg,
                                       input logic signed [REM_W-1:0] rem,
                                       input logic [ALPHA_W-1:0]      alpha);
        logic signed [REM_W-1:0]  remc;
        logic signed [AVG_W-1:0]  dq;
        logic signed [DIFF_W-1:0] diff;
        logic signed [ALPHA_W:0]  alpha_s;
        logic signed [PROD_W-1:0] prod;
        logic signed [P_W-1:0]    p;
        logic signed [P_W-1:0]    p_adj;
        logic signed [AVG_W-1:0]  avg_n;
        logic signed [SUM_W-1:0]  sum;
        logic signed [SUM_W-1:0]  sum_adj;
        logic signed [Q_W-1:0]    t;
        logic signed [7:0]        tsat;
        logic signed [R_W-1:0]    r;
        logic signed [REM_W-1:0]  rsat;
        t_axis                    res;

        // carry pointing against the new motion is dropped
        if ((d > 8'sd0 && rem < 0) || (d < 8'sd0 && rem > 0))
            remc = '0;
        else
            remc = rem;

        dq      = signed'({d, {FRAC{1'b0}}});
        diff    = DIFF_W'(dq) - DIFF_W'(avg);
        alpha_s = signed'({1'b0, alpha});
        prod    = PROD_W'(diff) * PROD_W'(alpha_s);
        p       = P_W'(prod) + (P_W'(avg) <<< FRAC);
        // truncate toward zero
        p_adj   = p + (p[P_W-1] ? signed'(P_W'(FRAC_MASK)) : signed'(P_W'(0)));
        avg_n   = p_adj[FRAC+AVG_W-1:FRAC];

        sum     = SUM_W'(avg_n) + SUM_W'(remc);
        sum_adj = sum + (sum[SUM_W-1] ? signed'(SUM_W'(FRAC_MASK))
                                      : signed'(SUM_W'(0)));
        t       = sum_adj[SUM_W-1:FRAC];
        if (t > Q_W'(127))
            tsat = 8'sd127;
        else if (t < -Q_W'(128))
            tsat = -8'sd128;
        else
            tsat = t[7:0];

        r = R_W'(sum) - (R_W'(tsat) <<< FRAC);
        if (r > signed'(R_W'(FRAC_MASK)))
            rsat = signed'(REM_W'(FRAC_MASK));
        else if (r < -signed'(R_W'(FRAC_MASK)))
            rsat = -signed'(REM_W'(FRAC_MASK));
        else
            rsat = r[REM_W-1:0];

        res.out = tsat;
        res.avg = avg_n;
        res.rem = rsat;
        return res;
    endfunction

endpackage

>>> sv/ema_pointer_smoother.sv
// An accepted item passes through the input register, a single-pass EMA
// update and the result register.
// Throughput: one item per cycle unless the output stalls; averages and
// carries feed back via one 25x18 multiplier per axis between the registers.
// Reset (i_rst_n low, synchronous): pipeline empty, averages, carries and
// last-motion time zero; factor 32768, timeout 100 ms, smoothing enabled.
module ema_pointer_smoother (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // stream in
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [47:0]                 i_s_tdata,  // delta_x, delta_y, now_ms
    // stream out
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [15:0]                 o_m_tdata,  // smooth_x, smooth_y
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [eps_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import eps_pkg::*;

    // configuration
    logic [FACTOR_W-1:0] r_factor;
    logic [31:0]         r_timeout;
    logic                r_en;

    // filter state
    logic signed [AVG_W-1:0] r_avg_x, r_avg_y, n_avg_x, n_avg_y;
    logic signed [REM_W-1:0] r_rem_x, r_rem_y, n_rem_x, n_rem_y;
    logic [31:0]             r_last, n_last;

    // input and result registers
    logic        r_in_vld;
    logic [47:0] r_in_data;
    logic        r_out_vld;
    logic [15:0] r_out_data, n_out_data;

    logic                adv;        // input stage moves into result register
    logic                cfg_wr;
    t_cfg_reg            cfg_idx;
    logic [FACTOR_W-1:0] factor_sat;
    logic [ALPHA_W-1:0]  alpha;
    t_axis               ax_x, ax_y;

    logic signed [7:0] dx, dy;
    logic [31:0]       now;
    logic [31:0]       idle;

    assign adv        = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_in_vld || adv;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign pready     = 1'b1;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_cfg_reg'(paddr[3:2]);

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            CFG_FACTOR:  prdata = 32'(r_factor);
            CFG_TIMEOUT: prdata = r_timeout;
            CFG_ENABLE:  prdata = 32'(r_en);
            default:     prdata = '0;
        endcase
    end

    // factors above 1.0 saturate to passthrough, then Q0.16 -> Q0.F
    assign factor_sat = (r_factor > FACTOR_ONE) ? FACTOR_ONE : r_factor;
    assign alpha      = ALPHA_W'((32'(factor_sat) << UP_SHIFT) >> DOWN_SHIFT);

    assign dx   = signed'(r_in_data[7:0]);
    assign dy   = signed'(r_in_data[15:8]);
    assign now  = r_in_data[47:16];
    assign idle = now - r_last;

    assign ax_x = eps_axis(dx, r_avg_x, r_rem_x, alpha);
    assign ax_y = eps_axis(dy, r_avg_y, r_rem_y, alpha);

    always_comb begin
        n_avg_x    = r_avg_x;
        n_avg_y    = r_avg_y;
        n_rem_x    = r_rem_x;
        n_rem_y    = r_rem_y;
        n_last     = r_last;
        n_out_data = r_in_data[15:0];   // passthrough when disabled
        if (r_in_vld && adv && r_en) begin
            if (dx == 8'sd0 && dy == 8'sd0) begin
                n_out_data = '0;
                // idle long enough: forget the history
                if (r_timeout != '0 && idle > r_timeout) begin
                    n_avg_x = '0;
                    n_avg_y = '0;
                    n_rem_x = '0;
                    n_rem_y = '0;
                end
            end else begin
                n_last     = now;
                n_avg_x    = ax_x.avg;
                n_avg_y    = ax_y.avg;
                n_rem_x    = ax_x.rem;
                n_rem_y    = ax_y.rem;
                n_out_data = {ax_y.out, ax_x.out};
            end
        end
        // turning smoothing off wipes the filter
        if (cfg_wr && cfg_idx == CFG_ENABLE && !pwdata[0]) begin
            n_avg_x = '0;
            n_avg_y = '0;
            n_rem_x = '0;
            n_rem_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor  <= FACTOR_W'(32768);
            r_timeout <= 32'd100;
            r_en      <= 1'b1;
            r_avg_x   <= '0;
            r_avg_y   <= '0;
            r_rem_x   <= '0;
            r_rem_y   <= '0;
            r_last    <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_avg_x <= n_avg_x;
            r_avg_y <= n_avg_y;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_last  <= n_last;

            if (cfg_wr) begin
                unique case (cfg_idx)
                    CFG_FACTOR:  r_factor  <= pwdata[FACTOR_W-1:0];
                    CFG_TIMEOUT: r_timeout <= pwdata;
                    CFG_ENABLE:  r_en      <= pwdata[0];
                    default:     ;
                endcase
            end

            if (o_s_tready)
                r_in_vld <= i_s_tvalid;
            if (adv)
                r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready)
            r_in_data <= i_s_tdata;
        if (r_in_vld && adv)
            r_out_data <= n_out_data;
    end

    // averages never exceed +127.0
    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_avg_x <= signed'(AVG_W'(127) <<< FRAC)) &&
        (r_avg_y <= signed'(AVG_W'(127) <<< FRAC)))
        else $error("average out of range");

    // carry magnitude stays below one
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem_x != signed'(REM_W'(1) << FRAC)) &&
        (r_rem_y != signed'(REM_W'(1) << FRAC)))
        else $error("carry out of range");

    // disabling clears the filter
    a_dis_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && cfg_idx == CFG_ENABLE && !pwdata[0]) |=>
        (r_avg_x == '0 && r_avg_y == '0 && r_rem_x == '0 && r_rem_y == '0))
        else $error("state not cleared on disable");

    // disabled: result equals the raw deltas
    a_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && adv && !r_en) |=> (r_out_data == $past(r_in_data[15:0])))
        else $error("passthrough mismatch");

    // a held input item is not lost while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> (r_in_vld && $stable(r_in_data)))
        else $error("stalled item lost");

endmodule
